// ===== rtl/rbst_pkg.sv =====
// Shared types and constants for the ray / box slab test block.
// No dependencies; imported by ray_box_slab_test_core.
package rbst_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int DIR_W         = 18;

  localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] T_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
  } box_in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] t_near;
  } slab_out_t;

endpackage

// ===== rtl/ray_box_slab_test_core.sv =====
// Ray against axis-aligned box slab test, fully pipelined.
// Depth: 39 register stages (2 prep stages, 33 divider stages, 3 combine
// stages, output register).
// Throughput: one box per cycle; a stalled output freezes the whole pipe, and the
// 33-stage restoring divider per plane (entry check plus one bit per stage) sets depth.
// Reset (rst, synchronous): empties the pipeline, origin to 0, dir to (0,0,-1.0).
// Uses rbst_pkg.
module ray_box_slab_test_core import rbst_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  box_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output slab_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int QW = 32;
  localparam int NW = 33 + FRAC_BITS;
  localparam int HW = NW - QW;
  localparam int RW = DIR_W + 1;
  localparam int CW = (HW > RW) ? HW : RW;

  logic signed [31:0]      org [0:2];
  logic signed [DIR_W-1:0] dir [0:2];

  logic                    en;

  // stage 1
  logic                    v1;
  logic signed [32:0]      diff1 [0:5];
  logic [2:0]              zd1, ok1, dneg1;
  logic [DIR_W-1:0]        dmag1 [0:2];
  // stage 2
  logic                    v2;
  logic [NW-1:0]           num2 [0:5];
  logic [5:0]              neg2;
  logic [2:0]              zd2, ok2;
  logic [DIR_W-1:0]        dmag2 [0:5];
  // divider stages
  logic                    dvv   [0:QW];
  logic [RW-1:0]           dvr   [0:QW][0:5];
  logic [QW-1:0]           dvn   [0:QW][0:5];
  logic [QW-1:0]           dvq   [0:QW][0:5];
  logic [DIR_W-1:0]        dvd   [0:QW][0:5];
  logic [5:0]              dvneg [0:QW];
  logic [5:0]              dvovf [0:QW];
  logic [2:0]              dvzd  [0:QW];
  logic [2:0]              dvok  [0:QW];
  logic [RW-1:0]           dvr_next [0:QW][0:5];
  logic [QW-1:0]           dvq_next [0:QW][0:5];
  logic [5:0]              dvovf0_next;
  // combine stages
  logic                    v3;
  logic signed [31:0]      ts3 [0:5];
  logic [2:0]              zd3, ok3;
  logic                    v4;
  logic signed [31:0]      enter4 [0:2];
  logic signed [31:0]      exit4  [0:2];
  logic [2:0]              ok4;
  logic                    v5;
  logic signed [31:0]      near5, far5;
  logic                    ok5;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = out_valid && out_stall;
  assign cfg_ready = 1'b1;

  // divider: overflow check at entry, then one quotient bit per stage
  always_comb begin
    logic [CW-1:0]   hi_ext;
    logic [RW-1:0]   rr;
    logic [RW:0]     trial;
    for (int l = 0; l < 6; l++) begin
      hi_ext = CW'(num2[l][NW-1:QW]);
      dvovf0_next[l] = hi_ext >= CW'(dmag2[l]);
      dvr_next[0][l] = dvovf0_next[l] ? '0 : hi_ext[RW-1:0];
      dvq_next[0][l] = '0;
    end
    for (int j = 1; j <= QW; j++) begin
      for (int l = 0; l < 6; l++) begin
        rr    = {dvr[j-1][l][RW-2:0], dvn[j-1][l][QW-1]};
        trial = {1'b0, rr} - {2'b00, dvd[j-1][l]};
        if (!trial[RW]) begin
          dvr_next[j][l] = trial[RW-1:0];
          dvq_next[j][l] = {dvq[j-1][l][QW-2:0], 1'b1};
        end else begin
          dvr_next[j][l] = rr;
          dvq_next[j][l] = {dvq[j-1][l][QW-2:0], 1'b0};
        end
      end
    end
  end

  // control and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      org[0] <= '0;
      org[1] <= '0;
      org[2] <= '0;
      dir[0] <= '0;
      dir[1] <= '0;
      dir[2] <= -18'sd65536;
      v1 <= 1'b0;
      v2 <= 1'b0;
      for (int j = 0; j <= QW; j++) dvv[j] <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_ORIGIN_X: org[0] <= cfg_data;
          REG_ORIGIN_Y: org[1] <= cfg_data;
          REG_ORIGIN_Z: org[2] <= cfg_data;
          REG_DIR_X:    dir[0] <= cfg_data[DIR_W-1:0];
          REG_DIR_Y:    dir[1] <= cfg_data[DIR_W-1:0];
          REG_DIR_Z:    dir[2] <= cfg_data[DIR_W-1:0];
          default: ;
        endcase
      end
      if (en) begin
        v1     <= in_valid;
        v2     <= v1;
        dvv[0] <= v2;
        for (int j = 1; j <= QW; j++) dvv[j] <= dvv[j-1];
        v3        <= dvv[QW];
        v4        <= v3;
        v5        <= v4;
        out_valid <= v5;
      end
    end
  end

  // datapath, advances with the whole pipe
  always_ff @(posedge clk) begin
    logic signed [31:0] lo, hi;
    logic [32:0]        mag;
    logic [QW-1:0]      q;
    logic signed [31:0] a, b, n01, f01;
    if (en) begin
      // stage 1: plane offsets, zero-direction slab check
      for (int ax = 0; ax < 3; ax++) begin
        case (ax)
          0:       begin lo = in_data.box_min_x; hi = in_data.box_max_x; end
          1:       begin lo = in_data.box_min_y; hi = in_data.box_max_y; end
          default: begin lo = in_data.box_min_z; hi = in_data.box_max_z; end
        endcase
        diff1[ax]   <= 33'(lo) - 33'(org[ax]);
        diff1[ax+3] <= 33'(hi) - 33'(org[ax]);
        zd1[ax]     <= (dir[ax] == '0);
        ok1[ax]     <= (dir[ax] != '0) || (lo <= org[ax] && org[ax] <= hi);
        dneg1[ax]   <= dir[ax][DIR_W-1];
        dmag1[ax]   <= dir[ax][DIR_W-1] ? DIR_W'(-dir[ax]) : dir[ax];
      end
      // stage 2: magnitudes and quotient signs
      for (int l = 0; l < 6; l++) begin
        mag       = diff1[l][32] ? 33'(-diff1[l]) : diff1[l];
        num2[l]  <= NW'(mag) << FRAC_BITS;
        neg2[l]  <= diff1[l][32] ^ dneg1[(l < 3) ? l : l - 3];
        dmag2[l] <= dmag1[(l < 3) ? l : l - 3];
      end
      zd2 <= zd1;
      ok2 <= ok1;
      // divider stages
      for (int l = 0; l < 6; l++) begin
        dvr[0][l] <= dvr_next[0][l];
        dvq[0][l] <= dvq_next[0][l];
        dvn[0][l] <= num2[l][QW-1:0];
        dvd[0][l] <= dmag2[l];
      end
      dvneg[0] <= neg2;
      dvovf[0] <= dvovf0_next;
      dvzd[0]  <= zd2;
      dvok[0]  <= ok2;
      for (int j = 1; j <= QW; j++) begin
        for (int l = 0; l < 6; l++) begin
          dvr[j][l] <= dvr_next[j][l];
          dvq[j][l] <= dvq_next[j][l];
          dvn[j][l] <= {dvn[j-1][l][QW-2:0], 1'b0};
          dvd[j][l] <= dvd[j-1][l];
        end
        dvneg[j] <= dvneg[j-1];
        dvovf[j] <= dvovf[j-1];
        dvzd[j]  <= dvzd[j-1];
        dvok[j]  <= dvok[j-1];
      end
      // saturate and apply sign
      for (int l = 0; l < 6; l++) begin
        q = dvq[QW][l];
        if (!dvneg[QW][l])
          ts3[l] <= (dvovf[QW][l] || q[QW-1]) ? T_MAX : q;
        else if (dvovf[QW][l] || (q[QW-1] && q[QW-2:0] != '0))
          ts3[l] <= T_MIN;
        else
          ts3[l] <= -q;
      end
      zd3 <= dvzd[QW];
      ok3 <= dvok[QW];
      // order each slab
      for (int ax = 0; ax < 3; ax++) begin
        a = ts3[ax];
        b = ts3[ax+3];
        if (zd3[ax]) begin
          enter4[ax] <= T_MIN;
          exit4[ax]  <= T_MAX;
        end else if (a > b) begin
          enter4[ax] <= b;
          exit4[ax]  <= a;
        end else begin
          enter4[ax] <= a;
          exit4[ax]  <= b;
        end
      end
      ok4 <= ok3;
      // intersect intervals
      n01   = (enter4[0] > enter4[1]) ? enter4[0] : enter4[1];
      f01   = (exit4[0] < exit4[1]) ? exit4[0] : exit4[1];
      near5 <= (n01 > enter4[2]) ? n01 : enter4[2];
      far5  <= (f01 < exit4[2]) ? f01 : exit4[2];
      ok5   <= &ok4;
      // result
      if (ok5 && near5 <= far5 && !far5[31]) begin
        out_data.hit    <= 1'b1;
        out_data.t_near <= near5;
      end else begin
        out_data.hit    <= 1'b0;
        out_data.t_near <= '0;
      end
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hit |-> out_data.t_near == '0)
    else $error("miss with nonzero t_near");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !v1 && !v5)
    else $error("pipeline not empty after reset");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> v1)
    else $error("accepted item missing from first stage");

  a_hit_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.hit |-> $past(near5 <= far5) || $past(!en))
    else $error("hit with empty interval");

endmodule
